// ===== hdl/binary_bitmap_match_score_core_assert.svh =====
// Assertion macros for the bitmap match score RTL.
// Needs nothing else; included by the files that check their own logic.
`ifndef BINARY_BITMAP_MATCH_SCORE_CORE_ASSERT_SVH
`define BINARY_BITMAP_MATCH_SCORE_CORE_ASSERT_SVH

// Same-cycle implication, quiet during reset
`define BBMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbms: implication check failed");

// Next-cycle implication, quiet during reset
`define BBMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbms: next-cycle check failed");

`endif

// ===== hdl/bbms_pkg.sv =====
// Types and constants for the bitmap match score core.
// No dependencies; used by the top-level core only.
`default_nettype none

package bbms_pkg;

   // Default bitmap limits
   localparam int MAX_WIDTH_DEFAULT  = 64;
   localparam int MAX_HEIGHT_DEFAULT = 64;

   // Fixed field widths
   localparam int OP_W     = 2;
   localparam int POS_W    = 6;
   localparam int SIZE_W   = 7;
   localparam int SCORE_W  = 18;
   localparam int SUM_W    = 14;
   localparam int AREA_W   = 13;
   localparam int FRAC_W   = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 2;

   // Operation codes carried on tuser
   typedef enum logic [OP_W-1:0] {
      OP_LOAD_FIRST  = 2'd0,
      OP_LOAD_SECOND = 2'd1,
      OP_COMPUTE     = 2'd2
   } op_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_HEIGHT = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/bbms_bitmap_ram.sv =====
// One-bit bitmap store: one write port, one registered read port.
// Depends on nothing; instantiated twice by the top level.
`default_nettype none

module bbms_bitmap_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic          wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic               rd_data_ff
);

   logic mem [DEPTH];

   // Write a pixel
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, updated only while rd_en is high
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bbms_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the score.
// Depends on nothing; used by the top level.
`default_nettype none

module bbms_divider #(
   parameter int NW = 30,
   parameter int DW = 13
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] numerator,
   input  wire logic [DW-1:0] divisor,
   output logic               done_ff,
   output logic [NW-1:0]      quot_ff
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff;
   logic [CW-1:0] count_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] div_ff;
   logic [DW:0]   trial;
   logic          take;

   // Bring down the next numerator bit and test against the divisor
   assign trial = {rem_ff, quot_ff[NW-1]};
   assign take  = (trial >= {1'b0, div_ff});

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (int'(count_ff) == NW - 1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: numerator shifts out as quotient bits shift in
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= numerator;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[NW-2:0], take};
         rem_ff  <= take ? DW'(trial - {1'b0, div_ff}) : DW'(trial);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/binary_bitmap_match_score_core.sv =====
// Bitmap match score core. Load words write one pixel and are taken one per cycle.
// A compute word walks the canvas one cell per cycle through the bitmap memories,
// then runs a one-bit-per-cycle divider for the score.
// New words wait while a compute runs; a finished result waits in the output register.
// Reset sets all sizes to 1 and the sum to zero; the bitmaps are not cleared.
`default_nettype none

module binary_bitmap_match_score_core #(
   parameter int MAX_WIDTH  = bbms_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bbms_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: row [5:0], column [11:6], pixel [12], zero [15:13]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [bbms_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: operation [1:0]
   input  wire logic [bbms_pkg::OP_W-1:0]           req_tuser,
   // rsp_tdata: score [17:0], agreement_sum [31:18], canvas_area [44:32], zero [47:45]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [bbms_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bbms_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bbms_pkg::SIZE_W-1:0]         csr_data
);

`include "binary_bitmap_match_score_core_assert.svh"

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WSZ   = $clog2(MAX_WIDTH + 1);
   localparam int HSZ   = $clog2(MAX_HEIGHT + 1);
   localparam int AREAW = $clog2(DEPTH + 1);
   localparam int SUMW  = AREAW + 1;
   localparam int NW    = AREAW + 1 + bbms_pkg::FRAC_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_START,
      S_DIVIDE,
      S_HOLD
   } state_type;

   // Clamp a size register into 1..limit
   function automatic logic [WSZ-1:0] clamp_w(input logic [bbms_pkg::SIZE_W-1:0] v);
      logic [WSZ-1:0] r;
      if (v == '0) begin
         r = WSZ'(1);
      end else if (int'(v) > MAX_WIDTH) begin
         r = WSZ'(MAX_WIDTH);
      end else begin
         r = WSZ'(v);
      end
      return r;
   endfunction

   function automatic logic [HSZ-1:0] clamp_h(input logic [bbms_pkg::SIZE_W-1:0] v);
      logic [HSZ-1:0] r;
      if (v == '0) begin
         r = HSZ'(1);
      end else if (int'(v) > MAX_HEIGHT) begin
         r = HSZ'(MAX_HEIGHT);
      end else begin
         r = HSZ'(v);
      end
      return r;
   endfunction

   // Configuration registers
   logic [bbms_pkg::SIZE_W-1:0] first_width_ff, first_height_ff;
   logic [bbms_pkg::SIZE_W-1:0] second_width_ff, second_height_ff;

   // Geometry of the current compute
   logic [WSZ-1:0] w1_ff, w2_ff, cw_ff;
   logic [HSZ-1:0] h1_ff, h2_ff, ch_ff;
   logic [XW-1:0]  ox1_ff, ox2_ff;
   logic [YW-1:0]  oy1_ff, oy2_ff;
   logic [AREAW-1:0] area_ff;
   logic [WSZ-1:0] w1_in, w2_in, cw_in;
   logic [HSZ-1:0] h1_in, h2_in, ch_in;

   // Scan and accumulate
   state_type             state_ff;
   logic [XW-1:0]         x_ff;
   logic [YW-1:0]         y_ff;
   logic                  cell_vld_ff, cov1_ff, cov2_ff;
   logic signed [SUMW-1:0] sum_ff;
   logic signed [SUMW-1:0] contrib;
   logic [XW-1:0]         lx1, lx2;
   logic [YW-1:0]         ly1, ly2;
   logic                  cov1, cov2, scanning, last_cell;
   logic [AW-1:0]         rd_addr1, rd_addr2;
   logic                  pix1, pix2;

   // Loads
   logic                  req_fire, load_ok, wr_en1, wr_en2;
   logic [AW-1:0]         wr_addr;
   logic [bbms_pkg::POS_W-1:0] req_row, req_col;
   logic                  req_pixel;

   // Divider
   logic                  div_start, div_done;
   logic signed [SUMW:0]  diff;
   logic [NW-1:0]         numerator, quot;

   // Output register
   logic                  rsp_valid_ff;
   logic [bbms_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                  out_free;

   assign req_row   = req_tdata[5:0];
   assign req_col   = req_tdata[11:6];
   assign req_pixel = req_tdata[12];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_width_ff   <= bbms_pkg::SIZE_W'(1);
         first_height_ff  <= bbms_pkg::SIZE_W'(1);
         second_width_ff  <= bbms_pkg::SIZE_W'(1);
         second_height_ff <= bbms_pkg::SIZE_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bbms_pkg::REG_FIRST_WIDTH:   first_width_ff   <= csr_data;
            bbms_pkg::REG_FIRST_HEIGHT:  first_height_ff  <= csr_data;
            bbms_pkg::REG_SECOND_WIDTH:  second_width_ff  <= csr_data;
            bbms_pkg::REG_SECOND_HEIGHT: second_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Canvas geometry from the clamped sizes
   assign w1_in = clamp_w(first_width_ff);
   assign h1_in = clamp_h(first_height_ff);
   assign w2_in = clamp_w(second_width_ff);
   assign h2_in = clamp_h(second_height_ff);
   assign cw_in = (w1_in > w2_in) ? w1_in : w2_in;
   assign ch_in = (h1_in > h2_in) ? h1_in : h2_in;

   always_ff @(posedge clock) begin
      if (req_fire && (req_tuser == bbms_pkg::OP_COMPUTE)) begin
         w1_ff   <= w1_in;
         h1_ff   <= h1_in;
         w2_ff   <= w2_in;
         h2_ff   <= h2_in;
         cw_ff   <= cw_in;
         ch_ff   <= ch_in;
         ox1_ff  <= XW'((cw_in - w1_in) >> 1);
         ox2_ff  <= XW'((cw_in - w2_in) >> 1);
         oy1_ff  <= YW'((ch_in - h1_in) >> 1);
         oy2_ff  <= YW'((ch_in - h2_in) >> 1);
         area_ff <= AREAW'(int'(cw_in) * int'(ch_in));
      end
   end

   // Load address; drop positions outside the store
   assign load_ok = (int'(req_row) < MAX_HEIGHT) && (int'(req_col) < MAX_WIDTH);
   assign wr_addr = AW'(int'(req_row) * MAX_WIDTH + int'(req_col));
   assign wr_en1  = req_fire && load_ok && (req_tuser == bbms_pkg::OP_LOAD_FIRST);
   assign wr_en2  = req_fire && load_ok && (req_tuser == bbms_pkg::OP_LOAD_SECOND);

   // Coverage of the current canvas cell by each bitmap
   assign scanning  = (state_ff == S_SCAN);
   assign lx1 = x_ff - ox1_ff;
   assign ly1 = y_ff - oy1_ff;
   assign lx2 = x_ff - ox2_ff;
   assign ly2 = y_ff - oy2_ff;
   assign cov1 = (x_ff >= ox1_ff) && (y_ff >= oy1_ff)
              && (int'(lx1) < int'(w1_ff)) && (int'(ly1) < int'(h1_ff));
   assign cov2 = (x_ff >= ox2_ff) && (y_ff >= oy2_ff)
              && (int'(lx2) < int'(w2_ff)) && (int'(ly2) < int'(h2_ff));
   assign rd_addr1 = AW'(int'(ly1) * MAX_WIDTH + int'(lx1));
   assign rd_addr2 = AW'(int'(ly2) * MAX_WIDTH + int'(lx2));
   assign last_cell = (int'(x_ff) == int'(cw_ff) - 1) && (int'(y_ff) == int'(ch_ff) - 1);

   bbms_bitmap_ram #(.DEPTH(DEPTH), .AW(AW)) u_first_ram (
      .clock      (clock),
      .wr_en      (wr_en1),
      .wr_addr    (wr_addr),
      .wr_data    (req_pixel),
      .rd_en      (scanning && cov1),
      .rd_addr    (rd_addr1),
      .rd_data_ff (pix1)
   );

   bbms_bitmap_ram #(.DEPTH(DEPTH), .AW(AW)) u_second_ram (
      .clock      (clock),
      .wr_en      (wr_en2),
      .wr_addr    (wr_addr),
      .wr_data    (req_pixel),
      .rd_en      (scanning && cov2),
      .rd_addr    (rd_addr2),
      .rd_data_ff (pix2)
   );

   // Per-cell contribution once the pixels are back
   always_comb begin
      contrib = '0;
      if (cov1_ff && cov2_ff) begin
         contrib = (pix1 == pix2) ? SUMW'(1) : -SUMW'(1);
      end else if (cov1_ff && !pix1) begin
         contrib = -SUMW'(1);
      end else if (cov2_ff && !pix2) begin
         contrib = -SUMW'(1);
      end
   end

   // Numerator (area - sum) with 16 fraction bits, so the quotient score is Q2.16
   assign diff      = $signed({2'b00, area_ff}) - (SUMW + 1)'(sum_ff);
   assign numerator = {diff[AREAW:0], {bbms_pkg::FRAC_W{1'b0}}};
   assign div_start = (state_ff == S_START);

   bbms_divider #(.NW(NW), .DW(AREAW)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (numerator),
      .divisor   (area_ff),
      .done_ff   (div_done),
      .quot_ff   (quot)
   );

   // Sequencer, accumulator and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         x_ff         <= '0;
         y_ff         <= '0;
         cell_vld_ff  <= 1'b0;
         cov1_ff      <= 1'b0;
         cov2_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         cell_vld_ff <= scanning;
         cov1_ff     <= scanning && cov1;
         cov2_ff     <= scanning && cov2;
         if (cell_vld_ff) begin
            sum_ff <= sum_ff + contrib;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire && (req_tuser == bbms_pkg::OP_COMPUTE)) begin
                  x_ff     <= '0;
                  y_ff     <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // Advance across the row, then down
               if (last_cell) begin
                  state_ff <= S_DRAIN;
               end else if (int'(x_ff) == int'(cw_ff) - 1) begin
                  x_ff <= '0;
                  y_ff <= y_ff + 1'b1;
               end else begin
                  x_ff <= x_ff + 1'b1;
               end
            end
            S_DRAIN:  state_ff <= S_START;
            S_START:  state_ff <= S_DIVIDE;
            S_DIVIDE: begin
               if (div_done) begin
                  state_ff <= S_HOLD;
               end
            end
            S_HOLD: begin
               // Hold the result until the output register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {3'b000,
                                   bbms_pkg::AREA_W'(area_ff),
                                   bbms_pkg::SUM_W'(sum_ff),
                                   bbms_pkg::SCORE_W'(quot)};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Checks
   `BBMS_ASSERT_IMPLY(a_div_done_in_divide, clock, reset, div_done, state_ff == S_DIVIDE)
   `BBMS_ASSERT_NEXT(a_hold_delivers, clock, reset, (state_ff == S_HOLD) && out_free, rsp_valid_ff && (state_ff == S_IDLE))
   `BBMS_ASSERT_IMPLY(a_sum_bounded, clock, reset, state_ff == S_START, (sum_ff <= $signed({2'b00, area_ff})) && (sum_ff >= -$signed({2'b00, area_ff})))

endmodule

`default_nettype wire
